@@ design/shfs_pkg.sv @@
package shfs_pkg;

  // Sizes
  localparam int VOTE_SAMPLES    = 10;
  localparam int TIMER_WIDTH     = 20;
  localparam int CFG_WIDTH       = 20;
  localparam int CFG_INDEX_WIDTH = 1;
  localparam int VOTE_CNT_WIDTH  = $clog2(VOTE_SAMPLES + 1);
  localparam int VOTE_THRESHOLD  = VOTE_SAMPLES / 2;
  localparam int CMP_WIDTH       = (TIMER_WIDTH > CFG_WIDTH) ? TIMER_WIDTH : CFG_WIDTH;

  // Register reset values
  localparam logic [CFG_WIDTH-1:0] STEP_INTERVAL_RESET = CFG_WIDTH'(2000);
  localparam logic [CFG_WIDTH-1:0] FAULT_TICKS_RESET   = CFG_WIDTH'(50000);

  // Register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_STEP_INTERVAL = CFG_INDEX_WIDTH'(0);
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FAULT_TICKS   = CFG_INDEX_WIDTH'(1);

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_LEAVE  = 2'd1,
    PH_RETURN = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    FLT_NONE    = 2'd0,
    FLT_ENDSTOP = 2'd1,
    FLT_TROUBLE = 2'd2
  } fault_e;

  // One accepted request
  typedef struct packed {
    logic [1:0]              action;
    logic [VOTE_SAMPLES-1:0] endstop_samples;
    logic                    endstop_level;
    logic                    trouble_level;
    logic                    permission_hold;
  } item_t;

  // Homing state as seen by the rest of the block
  typedef struct packed {
    logic   step;
    logic   dir;
    phase_e phase;
    logic   homed;
  } homing_status_t;

  // Majority vote over the endstop samples
  function automatic logic vote_high(logic [VOTE_SAMPLES-1:0] samples);
    logic [VOTE_CNT_WIDTH-1:0] ones;
    ones = '0;
    for (int i = 0; i < VOTE_SAMPLES; i++) begin
      ones = ones + VOTE_CNT_WIDTH'(samples[i]);
    end
    return ones > VOTE_CNT_WIDTH'(VOTE_THRESHOLD);
  endfunction

endpackage

@@ design/shfs_homing.sv @@
module shfs_homing (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             advance_i,
  input  shfs_pkg::item_t                  item_i,
  input  logic [shfs_pkg::CFG_WIDTH-1:0]   interval_i,
  output logic                             homed_next_o,
  output shfs_pkg::homing_status_t         status_o
);
  import shfs_pkg::*;

  phase_e               phase_q, phase_d;
  logic                 step_q, step_d;
  logic                 dir_q, dir_d;
  logic [CFG_WIDTH-1:0] acc_q, acc_d;
  logic                 due_q, due_d;
  logic                 homed_q, homed_d;
  logic [CFG_WIDTH-1:0] interval_eff;
  logic [CFG_WIDTH:0]   acc_wrap;
  logic                 due_now;
  logic                 endstop_high;

  assign interval_eff = (interval_i == '0) ? CFG_WIDTH'(1) : interval_i;
  assign acc_wrap     = {1'b0, acc_q} + (CFG_WIDTH + 1)'(1) - {1'b0, interval_eff};
  assign endstop_high = vote_high(item_i.endstop_samples);

  // Next homing state for the request in the input register
  always_comb begin
    phase_d = phase_q;
    step_d  = step_q;
    dir_d   = dir_q;
    acc_d   = acc_q;
    due_d   = due_q;
    homed_d = homed_q;
    due_now = due_q;
    unique case (item_i.action)
      ACT_START: begin
        phase_d = PH_LEAVE;
        dir_d   = 1'b1;
        homed_d = 1'b0;
        acc_d   = '0;
        due_d   = 1'b0;
      end
      ACT_CLEAR: begin
        homed_d = 1'b0;
      end
      default: begin
        if (phase_q == PH_LEAVE || phase_q == PH_RETURN) begin
          // Count time only while no step is pending
          if (!due_q) begin
            if (acc_q >= interval_eff) begin
              acc_d   = acc_wrap[CFG_WIDTH-1:0];
              due_now = 1'b1;
            end else begin
              acc_d = acc_q + CFG_WIDTH'(1);
            end
          end
          due_d = due_now;
          // Execute the pending step unless held
          if (due_now && !item_i.permission_hold) begin
            due_d = 1'b0;
            case (phase_q)
              PH_LEAVE: begin
                if (!endstop_high) begin
                  step_d = ~step_q;
                end else begin
                  phase_d = PH_RETURN;
                  dir_d   = 1'b0;
                end
              end
              PH_RETURN: begin
                if (!endstop_high) begin
                  homed_d = 1'b1;
                  phase_d = PH_IDLE;
                end else begin
                  step_d = ~step_q;
                end
              end
              default: begin
                phase_d = phase_q;
              end
            endcase
          end
        end
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      step_q  <= 1'b1;
      dir_q   <= 1'b0;
      acc_q   <= '0;
      due_q   <= 1'b0;
      homed_q <= 1'b0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      step_q  <= step_d;
      dir_q   <= dir_d;
      acc_q   <= acc_d;
      due_q   <= due_d;
      homed_q <= homed_d;
    end
  end

  assign homed_next_o   = homed_d;
  assign status_o.step  = step_q;
  assign status_o.dir   = dir_q;
  assign status_o.phase = phase_q;
  assign status_o.homed = homed_q;

endmodule

@@ design/shfs_monitor.sv @@
module shfs_monitor (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           advance_i,
  input  shfs_pkg::item_t                item_i,
  input  logic                           homed_next_i,
  input  logic [shfs_pkg::CFG_WIDTH-1:0] fault_ticks_i,
  output shfs_pkg::fault_e               fault_o
);
  import shfs_pkg::*;

  fault_e                 fault_q, fault_d;
  logic [TIMER_WIDTH-1:0] end_cnt_q, end_cnt_d;
  logic [TIMER_WIDTH-1:0] trb_cnt_q, trb_cnt_d;
  logic [CMP_WIDTH-1:0]   limit;

  assign limit = (fault_ticks_i == '0) ? CMP_WIDTH'(1) : CMP_WIDTH'(fault_ticks_i);

  // Next fault state; counters freeze while a fault is latched
  always_comb begin
    fault_d   = fault_q;
    end_cnt_d = end_cnt_q;
    trb_cnt_d = trb_cnt_q;
    if (item_i.action == ACT_CLEAR) begin
      fault_d   = FLT_NONE;
      end_cnt_d = '0;
      trb_cnt_d = '0;
    end else if (fault_q == FLT_NONE) begin
      if (homed_next_i && !item_i.endstop_level) begin
        end_cnt_d = (end_cnt_q == '1) ? end_cnt_q : end_cnt_q + TIMER_WIDTH'(1);
      end else begin
        end_cnt_d = '0;
      end
      if (!item_i.trouble_level) begin
        trb_cnt_d = (trb_cnt_q == '1) ? trb_cnt_q : trb_cnt_q + TIMER_WIDTH'(1);
      end else begin
        trb_cnt_d = '0;
      end
      // Endstop loss wins over driver trouble
      priority if (homed_next_i && !item_i.endstop_level &&
                   CMP_WIDTH'(end_cnt_d) >= limit) begin
        fault_d = FLT_ENDSTOP;
      end else if (!item_i.trouble_level && CMP_WIDTH'(trb_cnt_d) >= limit) begin
        fault_d = FLT_TROUBLE;
      end else begin
        fault_d = FLT_NONE;
      end
    end
  end

  // Hold fault state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_q   <= FLT_NONE;
      end_cnt_q <= '0;
      trb_cnt_q <= '0;
    end else if (advance_i) begin
      fault_q   <= fault_d;
      end_cnt_q <= end_cnt_d;
      trb_cnt_q <= trb_cnt_d;
    end
  end

  assign fault_o = fault_q;

endmodule

@@ design/stepper_homing_fault_supervisor.sv @@
// Channel   | Direction | Handshake               | Payload
// ----------+-----------+-------------------------+---------------------------------------------
// request   | in        | in_valid_i / in_ready_o | action, endstop_samples, endstop_level,
//           |           |                         | trouble_level, permission_hold
// result    | out       | out_valid_o/out_ready_i | step_level, direction_level, homing_phase,
//           |           |                         | homed, fault_code
// config    | in        | cfg_we_i (no wait)      | cfg_index_i, cfg_data_i
//
// A request lands in the input register, and when it advances its result moves into the
// state/result registers; one request per cycle sustained while the output is taken.
// The homing and fault state registers double as the result register; they advance only
// when the previous result is taken or gone, so a stalled output holds them.
// The input register takes a new request while a finished result waits, if it is empty.
// Reset clears all state to idle, step pin high, no fault, registers to their defaults.
module stepper_homing_fault_supervisor (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [1:0]                           action_i,
  input  logic [shfs_pkg::VOTE_SAMPLES-1:0]    endstop_samples_i,
  input  logic                                 endstop_level_i,
  input  logic                                 trouble_level_i,
  input  logic                                 permission_hold_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 step_level_o,
  output logic                                 direction_level_o,
  output logic [1:0]                           homing_phase_o,
  output logic                                 homed_o,
  output logic [1:0]                           fault_code_o,
  input  logic                                 cfg_we_i,
  input  logic [shfs_pkg::CFG_INDEX_WIDTH-1:0] cfg_index_i,
  input  logic [shfs_pkg::CFG_WIDTH-1:0]       cfg_data_i
);
  import shfs_pkg::*;

  logic                 in_valid_q;
  item_t                item_q;
  logic                 out_valid_q;
  logic                 advance;
  logic [CFG_WIDTH-1:0] interval_q;
  logic [CFG_WIDTH-1:0] fault_ticks_q;
  logic                 homed_next;
  homing_status_t       status;
  fault_e               fault;

  // Move the held request into the state when the result slot is free
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Capture requests
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.action          <= action_i;
      item_q.endstop_samples <= endstop_samples_i;
      item_q.endstop_level   <= endstop_level_i;
      item_q.trouble_level   <= trouble_level_i;
      item_q.permission_hold <= permission_hold_i;
    end
  end

  // Track the pending result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q    <= STEP_INTERVAL_RESET;
      fault_ticks_q <= FAULT_TICKS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_STEP_INTERVAL: interval_q    <= cfg_data_i;
        CFG_FAULT_TICKS:   fault_ticks_q <= cfg_data_i;
        default:           interval_q    <= interval_q;
      endcase
    end
  end

  shfs_homing u_homing (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (advance),
    .item_i       (item_q),
    .interval_i   (interval_q),
    .homed_next_o (homed_next),
    .status_o     (status)
  );

  shfs_monitor u_monitor (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (advance),
    .item_i        (item_q),
    .homed_next_i  (homed_next),
    .fault_ticks_i (fault_ticks_q),
    .fault_o       (fault)
  );

  assign out_valid_o       = out_valid_q;
  assign step_level_o      = status.step;
  assign direction_level_o = status.dir;
  assign homing_phase_o    = status.phase;
  assign homed_o           = status.homed;
  assign fault_code_o      = fault;

  // A processed start leaves the axis leaving the endstop, not homed
  a_start_enters_leave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && item_q.action == ACT_START |=>
      homing_phase_o == PH_LEAVE && direction_level_o && !homed_o)
    else $error("start request did not enter the leaving phase");

  // Homed only once the run has ended
  a_homed_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    homed_o |-> homing_phase_o == PH_IDLE)
    else $error("homed flag set during a homing run");

  // Direction follows the homing phase
  a_dir_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (homing_phase_o == PH_LEAVE |-> direction_level_o) and
    (homing_phase_o == PH_RETURN |-> !direction_level_o))
    else $error("direction does not match homing phase");

  // Every processed request produces a result
  a_advance_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("processed request produced no result");

endmodule

@@ tb/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import shfs_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int IDLE_PCT       = 9;
  localparam int DRAIN_CYCLES   = 4;
  localparam int HOLDOFF_AT     = 600;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int QUIET_FROM     = 1000;
  localparam int QUIET_TO       = 1300;

  // Action code the block does not define; it must behave as a tick
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Pin and status levels that come back for one request
  typedef struct packed {
    logic   step;
    logic   dir;
    phase_e phase;
    logic   homed;
    fault_e fault;
  } axis_result_t;

  logic                    clk_i             = 1'b0;
  logic                    rst_ni            = 1'b0;
  logic                    in_valid_i        = 1'b0;
  logic                    in_ready_o;
  logic [1:0]              action_i          = ACT_TICK;
  logic [VOTE_SAMPLES-1:0] endstop_samples_i = '0;
  logic                    endstop_level_i   = 1'b1;
  logic                    trouble_level_i   = 1'b1;
  logic                    permission_hold_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i       = 1'b0;
  logic                    step_level_o;
  logic                    direction_level_o;
  logic [1:0]              homing_phase_o;
  logic                    homed_o;
  logic [1:0]              fault_code_o;
  logic                    cfg_we_i          = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index_i    = CFG_STEP_INTERVAL;
  logic [CFG_WIDTH-1:0]    cfg_data_i        = '0;

  stepper_homing_fault_supervisor uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .action_i          (action_i),
    .endstop_samples_i (endstop_samples_i),
    .endstop_level_i   (endstop_level_i),
    .trouble_level_i   (trouble_level_i),
    .permission_hold_i (permission_hold_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .step_level_o      (step_level_o),
    .direction_level_o (direction_level_o),
    .homing_phase_o    (homing_phase_o),
    .homed_o           (homed_o),
    .fault_code_o      (fault_code_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Axis model: register copies and state
  logic [CFG_WIDTH-1:0]   interval_reg      = STEP_INTERVAL_RESET;
  logic [CFG_WIDTH-1:0]   fault_lim_reg     = FAULT_TICKS_RESET;
  phase_e                 axis_phase        = PH_IDLE;
  logic                   axis_step         = 1'b1;
  logic                   axis_dir          = 1'b0;
  logic [TIMER_WIDTH-1:0] step_acc          = '0;
  logic                   step_pending      = 1'b0;
  logic                   axis_homed        = 1'b0;
  logic [TIMER_WIDTH-1:0] endstop_low_ticks = '0;
  logic [TIMER_WIDTH-1:0] trouble_low_ticks = '0;
  fault_e                 axis_fault        = FLT_NONE;

  item_t        pending_reqs[$];
  axis_result_t axis_expected[$];
  item_t        next_req;
  axis_result_t want;
  int           queued_count  = 0;
  int           requests_sent = 0;
  int           results_seen  = 0;
  int           idle_cycles   = 0;
  int           mismatches    = 0;
  int           holdoff_left  = 0;
  logic         holdoff_done  = 1'b0;

  // Advance the axis by one request and return its pin levels
  function automatic axis_result_t advance_axis(item_t req);
    logic [CFG_WIDTH-1:0] iv;
    logic [CFG_WIDTH-1:0] lim;
    logic                 vote;
    fault_e               code;
    axis_result_t         res;
    iv   = (interval_reg == '0) ? CFG_WIDTH'(1) : interval_reg;
    lim  = (fault_lim_reg == '0) ? CFG_WIDTH'(1) : fault_lim_reg;
    vote = $countones(req.endstop_samples) > VOTE_THRESHOLD;
    if (req.action == ACT_CLEAR) begin
      // Clear leaves the homing phase alone and skips both monitors
      axis_homed        = 1'b0;
      axis_fault        = FLT_NONE;
      endstop_low_ticks = '0;
      trouble_low_ticks = '0;
    end else begin
      if (req.action == ACT_START) begin
        axis_phase   = PH_LEAVE;
        axis_dir     = 1'b1;
        axis_homed   = 1'b0;
        step_acc     = '0;
        step_pending = 1'b0;
      end else if (axis_phase != PH_IDLE) begin
        // Count time only while no step is waiting on permission
        if (!step_pending) begin
          if (step_acc >= iv) begin
            step_acc     = step_acc + 1'b1 - iv;
            step_pending = 1'b1;
          end else begin
            step_acc = step_acc + 1'b1;
          end
        end
        if (step_pending && !req.permission_hold) begin
          step_pending = 1'b0;
          if (axis_phase == PH_LEAVE) begin
            if (!vote) begin
              axis_step = ~axis_step;
            end else begin
              axis_phase = PH_RETURN;
              axis_dir   = 1'b0;
            end
          end else begin
            if (!vote) begin
              axis_homed = 1'b1;
              axis_phase = PH_IDLE;
            end else begin
              axis_step = ~axis_step;
            end
          end
        end
      end
      // Fault monitor; frozen while a code is latched, endstop loss wins a tie
      if (axis_fault == FLT_NONE) begin
        code = FLT_NONE;
        if (axis_homed && !req.endstop_level) begin
          if (endstop_low_ticks != '1) endstop_low_ticks = endstop_low_ticks + 1'b1;
          if (endstop_low_ticks >= lim) code = FLT_ENDSTOP;
        end else begin
          endstop_low_ticks = '0;
        end
        if (!req.trouble_level) begin
          if (trouble_low_ticks != '1) trouble_low_ticks = trouble_low_ticks + 1'b1;
          if (code == FLT_NONE && trouble_low_ticks >= lim) code = FLT_TROUBLE;
        end else begin
          trouble_low_ticks = '0;
        end
        axis_fault = code;
      end
    end
    res.step  = axis_step;
    res.dir   = axis_dir;
    res.phase = axis_phase;
    res.homed = axis_homed;
    res.fault = axis_fault;
    return res;
  endfunction

  // Driver: offer the next queued request, idling now and then
  always @(posedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_ready_o)) begin
      if (pending_reqs.size() != 0 &&
          ((requests_sent >= QUIET_FROM && requests_sent < QUIET_TO) ||
           $urandom_range(99) >= IDLE_PCT)) begin
        next_req          = pending_reqs.pop_front();
        action_i          <= next_req.action;
        endstop_samples_i <= next_req.endstop_samples;
        endstop_level_i   <= next_req.endstop_level;
        trouble_level_i   <= next_req.trouble_level;
        permission_hold_i <= next_req.permission_hold;
        in_valid_i        <= 1'b1;
        requests_sent++;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off to back up the block
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (holdoff_left != 0) begin
        holdoff_left <= holdoff_left - 1;
        out_ready_i  <= 1'b0;
      end else if (!holdoff_done && results_seen >= HOLDOFF_AT) begin
        holdoff_done <= 1'b1;
        holdoff_left <= HOLDOFF_CYCLES;
        out_ready_i  <= 1'b0;
      end else begin
        out_ready_i <= (results_seen >= QUIET_FROM && results_seen < QUIET_TO) ||
                       ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Monitor: predict on each accepted request, check each accepted result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        axis_expected.push_back(advance_axis(item_t'{action_i, endstop_samples_i,
                                                     endstop_level_i, trouble_level_i,
                                                     permission_hold_i}));
      end
      if (out_valid_o && out_ready_i) begin
        if (axis_expected.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          want = axis_expected.pop_front();
          if (step_level_o !== want.step) begin
            $error("step_level: expected %0d, got %0d", want.step, step_level_o);
            mismatches++;
          end
          if (direction_level_o !== want.dir) begin
            $error("direction_level: expected %0d, got %0d", want.dir, direction_level_o);
            mismatches++;
          end
          if (homing_phase_o !== want.phase) begin
            $error("homing_phase: expected %0d, got %0d", want.phase, homing_phase_o);
            mismatches++;
          end
          if (homed_o !== want.homed) begin
            $error("homed: expected %0d, got %0d", want.homed, homed_o);
            mismatches++;
          end
          if (fault_code_o !== want.fault) begin
            $error("fault_code: expected %0d, got %0d", want.fault, fault_code_o);
            mismatches++;
          end
        end
        results_seen <= results_seen + 1;
      end
      idle_cycles <= ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) ?
                     0 : idle_cycles + 1;
    end
  end

  // Watchdog: give up when nothing moves for too long
  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("FAIL");
    $finish;
  end

  task automatic push_req(input logic [1:0] act, input logic [VOTE_SAMPLES-1:0] samples,
                          input logic es_lvl, input logic tr_lvl, input logic hold);
    pending_reqs.push_back(item_t'{act, samples, es_lvl, tr_lvl, hold});
    queued_count++;
  endtask

  // Endstop reads that vote mostly one way, sometimes plain random
  function automatic logic [VOTE_SAMPLES-1:0] endstop_word(input logic pressed);
    logic [VOTE_SAMPLES-1:0] noise;
    noise = VOTE_SAMPLES'($urandom & $urandom & $urandom);
    if ($urandom_range(7) == 0) return VOTE_SAMPLES'($urandom);
    return pressed ? ~noise : noise;
  endfunction

  function automatic logic [1:0] run_action();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3) return ACT_CLEAR;
    if (r < 5) return ACT_START;
    if (r < 7) return ACT_UNUSED;
    return ACT_TICK;
  endfunction

  // One homing run: leave the switch, find it, come back off it, then dwell
  task automatic queue_homing_run();
    int unsigned seg_len;
    logic        troubled;
    logic        lost;
    logic        es_lvl;
    troubled = ($urandom_range(4) == 0);
    lost     = ($urandom_range(1) == 0);
    push_req(ACT_START, endstop_word(1'b0), 1'b1, 1'b1, 1'b0);
    for (int seg = 0; seg < 4; seg++) begin
      seg_len = (seg == 3) ? $urandom_range(0, 30) : $urandom_range(1, 14);
      for (int unsigned k = 0; k < seg_len; k++) begin
        if (seg == 3) es_lvl = lost ? ($urandom_range(9) == 0) : ($urandom_range(9) != 0);
        else          es_lvl = ($urandom_range(19) != 0);
        push_req(run_action(), endstop_word(seg == 1), es_lvl,
                 troubled ? ($urandom_range(9) == 0) : ($urandom_range(29) != 0),
                 $urandom_range(99) < 15);
      end
    end
  endtask

  task automatic queue_random(input int count);
    int target;
    target = queued_count + count;
    while (queued_count < target) begin
      if ($urandom_range(6) == 0) begin
        repeat ($urandom_range(1, 8)) begin
          push_req(2'($urandom_range(3)), VOTE_SAMPLES'($urandom), 1'($urandom),
                   1'($urandom), 1'($urandom));
        end
      end else begin
        queue_homing_run();
      end
    end
  endtask

  // Wait until every request is answered, then let the pipeline settle
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || in_valid_i || axis_expected.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [CFG_WIDTH-1:0] interval_val,
                            input logic [CFG_WIDTH-1:0] lim_val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_STEP_INTERVAL;
    cfg_data_i  <= interval_val;
    @(posedge clk_i);
    cfg_index_i <= CFG_FAULT_TICKS;
    cfg_data_i  <= lim_val;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    interval_reg  = interval_val;
    fault_lim_reg = lim_val;
  endtask

  task automatic run_phase(input logic [CFG_WIDTH-1:0] interval_val,
                           input logic [CFG_WIDTH-1:0] lim_val, input int count);
    wait_idle();
    set_config(interval_val, lim_val);
    queue_random(count);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Register defaults straight out of reset
    queue_random(6);
    wait_idle();
    set_config(CFG_WIDTH'(1), CFG_WIDTH'(2));

    // Directed: steps, held step, vote edges, both faults, tie, restart, clear mid-run
    push_req(ACT_START,  '0,       1'b1, 1'b1, 1'b0);
    push_req(ACT_TICK,   '0,       1'b1, 1'b1, 1'b0);
    push_req(ACT_TICK,   '0,       1'b1, 1'b1, 1'b1);
    push_req(ACT_TICK,   '0,       1'b1, 1'b1, 1'b1);
    push_req(ACT_TICK,   '0,       1'b1, 1'b1, 1'b0);
    push_req(ACT_TICK,   '1,       1'b1, 1'b1, 1'b0);
    push_req(ACT_TICK,   10'h3F0,  1'b1, 1'b1, 1'b0);
    push_req(ACT_TICK,   10'h01F,  1'b1, 1'b1, 1'b0);
    push_req(ACT_TICK,   10'h01F,  1'b1, 1'b1, 1'b0);
    push_req(ACT_TICK,   '0,       1'b0, 1'b1, 1'b0);
    push_req(ACT_TICK,   '0,       1'b0, 1'b1, 1'b0);
    push_req(ACT_CLEAR,  '1,       1'b0, 1'b0, 1'b1);
    push_req(ACT_UNUSED, 10'h2AA,  1'b1, 1'b0, 1'b0);
    push_req(ACT_UNUSED, 10'h155,  1'b1, 1'b0, 1'b0);
    push_req(ACT_CLEAR,  '0,       1'b1, 1'b1, 1'b0);
    push_req(ACT_START,  '0,       1'b1, 1'b1, 1'b0);
    push_req(ACT_TICK,   '0,       1'b1, 1'b1, 1'b0);
    push_req(ACT_START,  '1,       1'b1, 1'b1, 1'b0);
    push_req(ACT_TICK,   '1,       1'b1, 1'b1, 1'b0);
    push_req(ACT_CLEAR,  '1,       1'b1, 1'b1, 1'b0);
    push_req(ACT_TICK,   '1,       1'b1, 1'b1, 1'b0);
    push_req(ACT_TICK,   '0,       1'b1, 1'b1, 1'b0);
    push_req(ACT_TICK,   '0,       1'b1, 1'b1, 1'b0);
    push_req(ACT_TICK,   '0,       1'b0, 1'b0, 1'b0);
    push_req(ACT_TICK,   '0,       1'b0, 1'b0, 1'b0);

    // Random runs across several register settings, zero and full scale included
    run_phase(CFG_WIDTH'(1), CFG_WIDTH'(1), 400);
    run_phase(CFG_WIDTH'(3), CFG_WIDTH'(8), 400);
    run_phase('0, '0, 250);
    run_phase(CFG_WIDTH'(2), CFG_WIDTH'(25), 400);
    run_phase('1, '1, 120);
    run_phase(CFG_WIDTH'(4), CFG_WIDTH'(3), 260);

    wait_idle();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ stepper_homing_fault_supervisor.f @@
design/shfs_pkg.sv
design/shfs_homing.sv
design/shfs_monitor.sv
design/stepper_homing_fault_supervisor.sv
tb/tb.sv
